/* hw/rtl/cps_pkg.sv */
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants for the polynomial sine datapath
// Widths, Horner coefficients and shift selections for both precision
// modes: a single shift for Q24 and a per-cell selection for Q30.
// ----------------------------------------------------------------------------
package cps_pkg;

   // Phase and datapath widths
   localparam int PHASE_W   = 30;
   localparam int OUT_W     = 32;
   localparam int X_W       = 29;              // offset from quarter period
   localparam int SQ_W      = 2 * X_W;         // signed square
   localparam int X2_W      = 31;              // scaled square, unsigned
   localparam int ACC_W     = 34;              // Horner accumulator
   localparam int PROD_W    = ACC_W + X2_W + 1;
   localparam int NUM_CELLS = 5;

   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic        [X2_W-1:0]   x2_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // Precision mode codes
   typedef enum logic {
      MODE_Q24 = 1'b0,
      MODE_Q30 = 1'b1
   } mode_type;

   // Right shift applied after each Horner multiply
   typedef enum logic [1:0] {
      SHIFT_30 = 2'd0,
      SHIFT_32 = 2'd1,
      SHIFT_34 = 2'd2
   } shift_type;

   // Control that travels with each item down the chain
   typedef struct packed {
      logic     valid;
      mode_type mode;
      logic     neg;
   } ctl_type;

   // Mode Q24 starts the chain at zero so its first cell just loads the
   // leading coefficient; the last cell adds one in Q24.
   localparam acc_type ACC0_Q24 = '0;
   localparam acc_type ACC0_Q30 = -34'sd421101352;

   localparam acc_type COEF_Q24 [NUM_CELLS] = '{
      34'sd950108533, -34'sd1430910663, 34'sd1089453524, -34'sd331168742,
      34'sd16777216
   };

   localparam acc_type COEF_Q30 [NUM_CELLS] = '{
      34'sd1009356886, -34'sd1433689867, 34'sd1089501821, -34'sd1324675874,
      34'sd1073741824
   };

   localparam shift_type SHIFT_Q24 = SHIFT_32;

   localparam shift_type SHIFT_Q30 [NUM_CELLS] = '{
      SHIFT_34, SHIFT_34, SHIFT_34, SHIFT_32, SHIFT_30
   };

endpackage

/* hw/rtl/cps_square.sv */
// ----------------------------------------------------------------------------
// cps_square: phase folding and squaring front end
// Folds the phase to an offset from the quarter period, squares it and
// scales the square for the Horner chain. Two register stages.
// ----------------------------------------------------------------------------
module cps_square
   import cps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PHASE_W-1:0]  phase,
   input  mode_type            mode,
   output ctl_type             dn_ctl,
   output x2_type              dn_x2,
   output acc_type             dn_acc
);

   ctl_type                  ctl_x_ff,  ctl_x_in;
   logic signed [X_W-1:0]    x_ff,      x_in;
   ctl_type                  ctl_sq_ff;
   logic signed [SQ_W-1:0]   sq_ff,     sq_in;

   // Fold the phase: offset from the quarter point within the half period
   always_comb begin
      ctl_x_in.valid = start;
      ctl_x_in.mode  = mode;
      if (mode == MODE_Q30) begin
         x_in         = {~phase[28], phase[27:0]};
         ctl_x_in.neg = phase[29];
      end else begin
         x_in         = {{(X_W-22){~phase[22]}}, phase[21:0]};
         ctl_x_in.neg = phase[23];
      end
   end

   // Square the offset
   assign sq_in = x_ff * x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_x_ff.valid  <= 1'b0;
         ctl_sq_ff.valid <= 1'b0;
      end else begin
         ctl_x_ff.valid  <= ctl_x_in.valid;
         ctl_sq_ff.valid <= ctl_x_ff.valid;
      end
      ctl_x_ff.mode  <= ctl_x_in.mode;
      ctl_x_ff.neg   <= ctl_x_in.neg;
      x_ff           <= x_in;
      ctl_sq_ff.mode <= ctl_x_ff.mode;
      ctl_sq_ff.neg  <= ctl_x_ff.neg;
      sq_ff          <= sq_in;
   end

   // Scale the square and pick the chain's starting value
   always_comb begin
      dn_ctl = ctl_sq_ff;
      if (ctl_sq_ff.mode == MODE_Q30) begin
         dn_x2  = sq_ff[56:26];
         dn_acc = ACC0_Q30;
      end else begin
         dn_x2  = {2'b00, sq_ff[44:16]};
         dn_acc = ACC0_Q24;
      end
   end

endmodule

/* hw/rtl/cps_cell.sv */
// ----------------------------------------------------------------------------
// cps_cell: one Horner step
// Multiplies the incoming accumulator by the scaled square, then shifts
// right with floor rounding and adds the coefficient. Two register stages.
// ----------------------------------------------------------------------------
module cps_cell
   import cps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  acc_type   coef_q24,
   input  acc_type   coef_q30,
   input  shift_type shift_q30,
   input  ctl_type   up_ctl,
   input  x2_type    up_x2,
   input  acc_type   up_acc,
   output ctl_type   dn_ctl,
   output x2_type    dn_x2,
   output acc_type   dn_acc
);

   ctl_type  ctl_a_ff;
   x2_type   x2_a_ff;
   prod_type prod_ff, prod_in;
   ctl_type  ctl_b_ff;
   x2_type   x2_b_ff;
   acc_type  acc_ff,  acc_in;
   prod_type shifted;
   shift_type shift_sel;

   // Multiply accumulator by the scaled square
   assign prod_in = up_acc * $signed({1'b0, up_x2});

   // Floor shift and add the coefficient of this step
   always_comb begin
      shift_sel = (ctl_a_ff.mode == MODE_Q30) ? shift_q30 : SHIFT_Q24;
      unique case (shift_sel)
         SHIFT_30: shifted = prod_ff >>> 30;
         SHIFT_32: shifted = prod_ff >>> 32;
         SHIFT_34: shifted = prod_ff >>> 34;
         default:  shifted = prod_ff >>> 34;
      endcase
      acc_in = shifted[ACC_W-1:0]
             + ((ctl_a_ff.mode == MODE_Q30) ? coef_q30 : coef_q24);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
         ctl_b_ff.valid <= 1'b0;
      end else begin
         ctl_a_ff.valid <= up_ctl.valid;
         ctl_b_ff.valid <= ctl_a_ff.valid;
      end
      ctl_a_ff.mode <= up_ctl.mode;
      ctl_a_ff.neg  <= up_ctl.neg;
      x2_a_ff       <= up_x2;
      prod_ff       <= prod_in;
      ctl_b_ff.mode <= ctl_a_ff.mode;
      ctl_b_ff.neg  <= ctl_a_ff.neg;
      x2_b_ff       <= x2_a_ff;
      acc_ff        <= acc_in;
   end

   assign dn_ctl = ctl_b_ff;
   assign dn_x2  = x2_b_ff;
   assign dn_acc = acc_ff;

endmodule

/* hw/rtl/chebyshev_poly_sine.sv */
// ----------------------------------------------------------------------------
// chebyshev_poly_sine: fixed-point sine by even polynomial, chained cells
// Phase folding, a squaring front end, five Horner cells and a sign stage.
// ----------------------------------------------------------------------------
// Takes one phase item in every clock cycle (busy is always low) and returns
// its sine on rsp_sine_value with rsp_strobe high for one cycle;
// the receiver cannot stall, so every result must be taken as it appears.
// The result passes through the chain: two stages to fold and square the
// phase, two stages per Horner cell (multiply, then shift and add) for five
// cells, and one output stage. The mode register selects Q24 (24-bit phase
// period) or Q30 (30-bit phase period); write it only while no items are in
// flight. In the upper half period the result is the bitwise complement of
// the cosine-shaped value, one below the exact negation.
module chebyshev_poly_sine
   import cps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [PHASE_W-1:0] req_phase,
   output logic               rsp_strobe,
   output logic [OUT_W-1:0]   rsp_sine_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_wdata
);

   mode_type mode_ff, mode_in;
   ctl_type  chain_ctl [NUM_CELLS+1];
   x2_type   chain_x2  [NUM_CELLS+1];
   acc_type  chain_acc [NUM_CELLS+1];
   logic     strobe_ff;
   logic [OUT_W-1:0] value_ff, value_in;

   // Always accept items and register writes
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Hold the precision mode
   assign mode_in = csr_valid ? mode_type'(csr_wdata) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_Q24;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Fold and square the phase
   cps_square u_square (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .phase  (req_phase),
      .mode   (mode_ff),
      .dn_ctl (chain_ctl[0]),
      .dn_x2  (chain_x2[0]),
      .dn_acc (chain_acc[0])
   );

   // Horner chain
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      cps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .coef_q24  (COEF_Q24[i]),
         .coef_q30  (COEF_Q30[i]),
         .shift_q30 (SHIFT_Q30[i]),
         .up_ctl    (chain_ctl[i]),
         .up_x2     (chain_x2[i]),
         .up_acc    (chain_acc[i]),
         .dn_ctl    (chain_ctl[i+1]),
         .dn_x2     (chain_x2[i+1]),
         .dn_acc    (chain_acc[i+1])
      );
   end

   // Truncate and complement in the upper half period
   assign value_in = chain_ctl[NUM_CELLS].neg ? ~chain_acc[NUM_CELLS][OUT_W-1:0]
                                              :  chain_acc[NUM_CELLS][OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain_ctl[NUM_CELLS].valid;
      end
      value_ff <= value_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_sine_value = value_ff;

   // The scaled square of the last cell is not needed past the chain
   logic unused_x2;
   assign unused_x2 = ^chain_x2[NUM_CELLS];

endmodule

/* bench/tb_chebyshev_poly_sine.sv */
// ----------------------------------------------------------------------------
// tb_chebyshev_poly_sine: self-checking bench for the polynomial sine block
// Feeds phase items through the start/busy port and predicts each sine value
// with an independent Horner evaluation in 64-bit signed arithmetic. The
// scoreboard checks results in order as they appear on the strobed port.
// Both precision modes are visited several times, first with directed
// corner phases and then with random phases, gaps and back-to-back bursts.
// ----------------------------------------------------------------------------
module tb_chebyshev_poly_sine;
   import cps_pkg::*;

   // Polynomial coefficients and shifts, highest power first
   localparam longint Q24_POLY [4] = '{950108533, -1430910663, 1089453524, -331168742};
   localparam longint Q24_UNITY    = 64'sd16777216;
   localparam longint Q30_POLY [5] = '{-421101352, 1009356886, -1433689867, 1089501821,
                                       -1324675874};
   localparam int     Q30_SHIFT [5] = '{34, 34, 34, 32, 30};
   localparam longint Q30_UNITY    = 64'sd1073741824;

   localparam int RANDOM_BLOCKS  = 6;
   localparam int ITEMS_PER_BLOCK = 170;
   localparam int DRAIN_CYCLES   = 20;

   localparam logic [PHASE_W-1:0] Q24_CORNERS [10] = '{
      30'h0000000, 30'h0400000, 30'h0800000, 30'h0C00000, 30'h0FFFFFF,
      30'h07FFFFF, 30'h3FFFFFFF, 30'h3F000000, 30'h0000001, 30'h0800001
   };
   localparam logic [PHASE_W-1:0] Q30_CORNERS [10] = '{
      30'h00000000, 30'h10000000, 30'h20000000, 30'h30000000, 30'h3FFFFFFF,
      30'h1FFFFFFF, 30'h00000001, 30'h20000001, 30'h2AAAAAAA, 30'h15555555
   };

   typedef struct {
      logic [PHASE_W-1:0] phase;
      mode_type           mode;
      logic [OUT_W-1:0]   sine;
   } pending_sine_type;

   // Predict sine values and check them in arrival order
   class sine_scoreboard;
      pending_sine_type pending_sines[$];
      mode_type      mode;
      int            errors;

      function new();
         mode   = MODE_Q24;
         errors = 0;
      endfunction

      function void set_mode(mode_type m);
         mode = m;
      endfunction

      function int pending();
         return pending_sines.size();
      endfunction

      // Fold the phase around the quarter point and run Horner on x^2
      function logic [OUT_W-1:0] compute_sine(logic [PHASE_W-1:0] ph, mode_type m);
         longint     x;
         longint     x2;
         longint     acc;
         logic [31:0] y;
         logic       upper;
         int         i;
         if (m == MODE_Q24) begin
            x   = longint'(ph[22:0]) - (64'sd1 <<< 22);
            x2  = (x * x) >>> 16;
            acc = Q24_POLY[0];
            for (i = 1; i < 4; i++)
               acc = ((acc * x2) >>> 32) + Q24_POLY[i];
            acc   = ((acc * x2) >>> 32) + Q24_UNITY;
            upper = ph[23];
         end else begin
            x   = longint'(ph[28:0]) - (64'sd1 <<< 28);
            x2  = (x * x) >>> 26;
            acc = Q30_POLY[0];
            for (i = 1; i < 5; i++)
               acc = ((acc * x2) >>> Q30_SHIFT[i-1]) + Q30_POLY[i];
            acc   = ((acc * x2) >>> Q30_SHIFT[4]) + Q30_UNITY;
            upper = ph[29];
         end
         y = acc[31:0];
         // Complement in the upper half period
         if (upper)
            y = ~y;
         return y;
      endfunction

      function void note_phase(logic [PHASE_W-1:0] ph);
         pending_sine_type p;
         p.phase = ph;
         p.mode  = mode;
         p.sine  = compute_sine(ph, mode);
         pending_sines.push_back(p);
      endfunction

      function void check_sine(logic [OUT_W-1:0] actual);
         pending_sine_type p;
         if (pending_sines.size() == 0) begin
            $display("%0t: unexpected sine_value %h, expected none", $time, actual);
            errors++;
            return;
         end
         p = pending_sines.pop_front();
         if (actual !== p.sine) begin
            $display("%0t: sine_value mismatch, phase %h mode %0d: expected %h, actual %h",
                     $time, p.phase, p.mode, p.sine, actual);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [PHASE_W-1:0] req_phase;
   logic               rsp_strobe;
   logic [OUT_W-1:0]   rsp_sine_value;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_wdata;

   sine_scoreboard sine_board;
   logic           steady;

   chebyshev_poly_sine DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_phase      (req_phase),
      .rsp_strobe     (rsp_strobe),
      .rsp_sine_value (rsp_sine_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check every strobed result at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sine_board.check_sine(rsp_sine_value);
   end

   // Present one phase after a random gap and hold it until accepted
   task automatic send_phase(input logic [PHASE_W-1:0] ph);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req_phase <= ph;
      do @(posedge clock); while (busy !== 1'b0);
      sine_board.note_phase(ph);
   endtask

   // Drain the pipeline, then write the mode register
   task automatic write_mode(input mode_type m);
      @(negedge clock);
      start <= 1'b0;
      while (sine_board.pending() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sine_board.set_mode(m);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mix of uniform phases, quarter-point neighborhoods and both extremes
   function automatic logic [PHASE_W-1:0] random_phase(mode_type m);
      logic [PHASE_W-1:0] ph;
      int                 kind;
      kind = $urandom_range(0, 4);
      case (kind)
         0, 1: ph = 30'($urandom());
         2: begin
            if (m == MODE_Q24)
               ph = (30'($urandom_range(0, 3)) << 22) + 30'($urandom_range(0, 64)) - 30'd32
                    | (30'($urandom_range(0, 63)) << 24);
            else
               ph = (30'($urandom_range(0, 3)) << 28) + 30'($urandom_range(0, 64)) - 30'd32;
         end
         3: ph = 30'($urandom_range(0, 15));
         default: ph = 30'h3FFFFFFF - 30'($urandom_range(0, 15));
      endcase
      return ph;
   endfunction

   initial begin
      int blk;
      int n;
      mode_type m;
      sine_board = new();
      steady     = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_phase  = '0;
      csr_valid  = 1'b0;
      csr_wdata  = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed corners in each mode
      write_mode(MODE_Q24);
      foreach (Q24_CORNERS[k])
         send_phase(Q24_CORNERS[k]);
      write_mode(MODE_Q30);
      foreach (Q30_CORNERS[k])
         send_phase(Q30_CORNERS[k]);

      // Random blocks, alternating modes
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         m = (blk % 2 == 0) ? MODE_Q24 : MODE_Q30;
         write_mode(m);
         for (n = 0; n < ITEMS_PER_BLOCK; n++) begin
            if (n % 32 == 0)
               steady = ($urandom_range(0, 2) == 0);
            send_phase(random_phase(m));
         end
      end

      // Drop start and wait for the tail of the pipeline
      @(negedge clock);
      start <= 1'b0;
      while (sine_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sine_board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hold a hard limit on the run
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
